[hdl/assert_macros.svh]
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst_n, a, c, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (c)) \
		else $error(msg);
`define ASSERT_NEXT(label, clk, rst_n, a, c, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (c)) \
		else $error(msg);
`else
`define ASSERT_IMPLIES(label, clk, rst_n, a, c, msg)
`define ASSERT_NEXT(label, clk, rst_n, a, c, msg)
`endif
`endif

[hdl/srip_pkg.sv]
// types, constants and codes of the signed radix integer parser
`default_nettype none
package srip_pkg;

	localparam int RADIX_W = 6;
	localparam int MAG_W = 64;
	localparam int PROD_W = MAG_W + RADIX_W;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [RADIX_W-1:0] MIN_RADIX = 6'd2;
	localparam logic [RADIX_W-1:0] MAX_RADIX = 6'd36;
	localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;

	localparam logic [PROD_W-1:0] LIMIT_POS = PROD_W'((65'd1 << 63) - 65'd1);
	localparam logic [PROD_W-1:0] LIMIT_NEG = PROD_W'(65'd1 << 63);

	localparam logic [7:0] CH_0 = 8'h30;
	localparam logic [7:0] CH_9 = 8'h39;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_Z = 8'h5A;
	localparam logic [7:0] CH_A = 8'h61;
	localparam logic [7:0] CH_Z = 8'h7A;
	localparam logic [7:0] CASE_BIT = 8'h20;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_VT = 8'h0B;
	localparam logic [7:0] CH_FF = 8'h0C;
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_PLUS = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [RADIX_W-1:0] ALPHA_BASE = 6'd10;

	typedef enum logic [2:0] {
		K_BAD_RADIX = 3'd0,
		K_SPACE     = 3'd1,
		K_PLUS      = 3'd2,
		K_MINUS     = 3'd3,
		K_DIGIT     = 3'd4,
		K_STRAY     = 3'd5
	} kind_t;

	typedef struct packed {
		kind_t              kind;
		logic [RADIX_W-1:0] digit;
		logic [RADIX_W-1:0] radix;
		logic               last;
	} entry_t;

	typedef enum logic [3:0] {
		PH_LEAD   = 4'b0001,
		PH_SIGN   = 4'b0010,
		PH_DIGITS = 4'b0100,
		PH_TRAIL  = 4'b1000
	} phase_t;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_MUL  = 3'b010,
		ST_FIN  = 3'b100
	} bst_t;

	typedef struct packed {
		logic emit;
		logic idle;
	} bk_stat_t;

endpackage
`default_nettype wire

[hdl/signed_radix_integer_parser_unit.sv]
// top level of the signed radix integer parser
// Parses text one byte per request into a signed 64-bit integer.
// Input channel in_valid/in_ready carries character and last; last marks the final
// byte of a string. Leading whitespace, an optional sign, digits in the current radix
// and trailing whitespace make a valid string. Each string gives one result on the
// out_valid/out_ready channel: value and ok (value is zero when ok is low).
// The cfg_valid/cfg_ready channel writes the radix (reset 10); write it only while idle.
// A front classifier feeds a small queue; the back end holds the string state.
// In the back end a digit is loaded, then takes six shift-add steps of the 64-bit
// magnitude (one radix bit each), and a finish step adds the digit and checks the range.
// Any other byte, or a digit after a failure, is loaded and then finished. The result
// register is loaded at the end of the final byte's finish step. When out_ready is low
// the result holds, the back end stalls on the next final byte, and the queue fills
// before in_ready drops.
// Reset clears the string state, empties the queue and drops out_valid.
`default_nettype none
`include "assert_macros.svh"
module signed_radix_integer_parser_unit #(
	parameter int QUEUE_DEPTH = srip_pkg::QUEUE_DEPTH
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [7:0]                        character,
	input  logic                              last,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [srip_pkg::MAG_W-1:0] value,
	output logic                              ok,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [srip_pkg::RADIX_W-1:0]      radix
);
	import srip_pkg::*;

	logic [RADIX_W-1:0] radix_q;
	entry_t             cls_entry;
	entry_t             q_data;
	logic               q_valid;
	logic               pop;
	bk_stat_t           bk_stat;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= RADIX_RESET;
		end else if (cfg_valid && cfg_ready) begin
			radix_q <= radix;
		end
	end

	srip_classify u_classify (
		.character (character),
		.last      (last),
		.radix     (radix_q),
		.entry     (cls_entry)
	);

	srip_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (in_valid),
		.push_ready (in_ready),
		.push_data  (cls_entry),
		.pop        (pop),
		.pop_valid  (q_valid),
		.pop_data   (q_data)
	);

	srip_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_data    (q_data),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.value     (value),
		.ok        (ok),
		.stat      (bk_stat)
	);

	`ASSERT_IMPLIES(a_full_not_empty, clk, arst_n, !in_ready, q_valid, "queue full but empty")
	`ASSERT_IMPLIES(a_pop_valid, clk, arst_n, pop, q_valid && bk_stat.idle, "pop without request")
	`ASSERT_IMPLIES(a_emit_free, clk, arst_n, bk_stat.emit, !out_valid || out_ready, "result overwritten")
	`ASSERT_NEXT(a_emit_shown, clk, arst_n, bk_stat.emit, out_valid, "result not presented")
	`ASSERT_IMPLIES(a_fail_zero, clk, arst_n, out_valid && !ok, value == '0, "failed value not zero")

endmodule
`default_nettype wire

[hdl/srip_classify.sv]
// front end: sorts each character into a kind and digit value
`default_nettype none
module srip_classify (
	input  logic [7:0]                   character,
	input  logic                         last,
	input  logic [srip_pkg::RADIX_W-1:0] radix,
	output srip_pkg::entry_t             entry
);
	import srip_pkg::*;

	logic [7:0]         lowered;
	logic [RADIX_W-1:0] dval;
	logic               is_dec;
	logic               is_alpha;
	logic               is_space;
	logic               radix_bad;

	always_comb begin
		lowered = character;
		if (character >= CH_UPPER_A && character <= CH_UPPER_Z) begin
			lowered = character | CASE_BIT;
		end
		is_dec = character >= CH_0 && character <= CH_9;
		is_alpha = lowered >= CH_A && lowered <= CH_Z;
		is_space = character == CH_SPACE || character == CH_TAB || character == CH_LF ||
			character == CH_VT || character == CH_FF || character == CH_CR;
		radix_bad = radix < MIN_RADIX || radix > MAX_RADIX;
		dval = is_dec ? RADIX_W'(character - CH_0) : RADIX_W'(lowered - CH_A) + ALPHA_BASE;

		entry.digit = dval;
		entry.radix = radix;
		entry.last = last;
		if (radix_bad) begin
			entry.kind = K_BAD_RADIX;
		end else if (is_space) begin
			entry.kind = K_SPACE;
		end else if (character == CH_PLUS) begin
			entry.kind = K_PLUS;
		end else if (character == CH_MINUS) begin
			entry.kind = K_MINUS;
		end else if ((is_dec || is_alpha) && dval < radix) begin
			entry.kind = K_DIGIT;
		end else begin
			entry.kind = K_STRAY;
		end
	end

endmodule
`default_nettype wire

[hdl/srip_queue.sv]
// small request queue between the classifier and the accumulator
`default_nettype none
module srip_queue #(
	parameter int DEPTH = srip_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  srip_pkg::entry_t push_data,
	input  logic             pop,
	output logic             pop_valid,
	output srip_pkg::entry_t pop_data
);
	import srip_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	entry_t          mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   cnt_q;
	logic            do_push;
	logic            do_pop;

	assign push_ready = cnt_q != CW'(DEPTH);
	assign pop_valid = cnt_q != '0;
	assign pop_data = mem_q[rd_ptr_q];
	assign do_push = push_valid && push_ready;
	assign do_pop = pop && pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!do_push && do_pop) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule
`default_nettype wire

[hdl/srip_back.sv]
// back end: string state, shift-add accumulate, range check and result register
`default_nettype none
module srip_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       q_valid,
	input  srip_pkg::entry_t           q_data,
	output logic                       pop,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic signed [srip_pkg::MAG_W-1:0] value,
	output logic                       ok,
	output srip_pkg::bk_stat_t         stat
);
	import srip_pkg::*;

	localparam int STEP_W = $clog2(RADIX_W);

	bst_t               st_q;
	logic [STEP_W-1:0]  step_q;
	phase_t             phase_q;
	logic               neg_q;
	logic [MAG_W-1:0]   mag_q;
	logic               failed_q;
	logic               out_valid_q;
	entry_t             cur_q;
	logic [PROD_W-1:0]  acc_q;
	logic [PROD_W-1:0]  mcand_q;
	logic [RADIX_W-1:0] mr_q;
	logic [MAG_W-1:0]   value_q;
	logic               ok_q;

	phase_t             ph_n;
	logic               neg_n;
	logic [MAG_W-1:0]   mag_n;
	logic               fail_n;
	logic [PROD_W-1:0]  sum;
	logic [PROD_W-1:0]  limit;
	logic               out_free;
	logic               fin_go;
	logic               emit;
	logic               done_ok;
	logic [MAG_W-1:0]   res_val;
	logic               start_mul;

	assign out_free = !out_valid_q || out_ready;
	assign pop = st_q == ST_IDLE && q_valid;
	assign start_mul = q_data.kind == K_DIGIT && !failed_q;
	assign fin_go = st_q == ST_FIN && (!cur_q.last || out_free);
	assign emit = fin_go && cur_q.last;

	assign out_valid = out_valid_q;
	assign value = value_q;
	assign ok = ok_q;
	assign stat.emit = emit;
	assign stat.idle = st_q == ST_IDLE;

	// update of the string state for the item in hand
	always_comb begin
		ph_n = phase_q;
		neg_n = neg_q;
		mag_n = mag_q;
		fail_n = failed_q;
		sum = acc_q + PROD_W'(cur_q.digit);
		limit = neg_q ? LIMIT_NEG : LIMIT_POS;
		if (!failed_q) begin
			case (cur_q.kind)
				K_SPACE: begin
					if (phase_q == PH_SIGN) begin
						fail_n = 1'b1;
					end else if (phase_q == PH_DIGITS) begin
						ph_n = PH_TRAIL;
					end
				end
				K_PLUS, K_MINUS: begin
					if (phase_q == PH_LEAD) begin
						neg_n = cur_q.kind == K_MINUS;
						ph_n = PH_SIGN;
					end else begin
						fail_n = 1'b1;
					end
				end
				K_DIGIT: begin
					if (phase_q == PH_TRAIL) begin
						fail_n = 1'b1;
					end else begin
						ph_n = PH_DIGITS;
						if (sum > limit) begin
							fail_n = 1'b1;
						end else begin
							mag_n = sum[MAG_W-1:0];
						end
					end
				end
				default: begin
					fail_n = 1'b1;
				end
			endcase
		end
		done_ok = !fail_n && (ph_n == PH_DIGITS || ph_n == PH_TRAIL);
		res_val = neg_n ? (MAG_W'(0) - mag_n) : mag_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			step_q <= '0;
			phase_q <= PH_LEAD;
			neg_q <= 1'b0;
			mag_q <= '0;
			failed_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (st_q)
				ST_IDLE: begin
					if (q_valid) begin
						step_q <= '0;
						st_q <= start_mul ? ST_MUL : ST_FIN;
					end
				end
				ST_MUL: begin
					step_q <= step_q + 1'b1;
					if (step_q == STEP_W'(RADIX_W - 1)) begin
						st_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (fin_go) begin
						st_q <= ST_IDLE;
						if (cur_q.last) begin
							phase_q <= PH_LEAD;
							neg_q <= 1'b0;
							mag_q <= '0;
							failed_q <= 1'b0;
						end else begin
							phase_q <= ph_n;
							neg_q <= neg_n;
							mag_q <= mag_n;
							failed_q <= fail_n;
						end
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	// multiply datapath, one radix bit per cycle, and the result register
	always_ff @(posedge clk) begin
		if (emit) begin
			value_q <= done_ok ? res_val : '0;
			ok_q <= done_ok;
		end
		case (st_q)
			ST_IDLE: begin
				if (q_valid) begin
					cur_q <= q_data;
					acc_q <= '0;
					mcand_q <= PROD_W'(mag_q);
					mr_q <= q_data.radix;
				end
			end
			ST_MUL: begin
				if (mr_q[0]) begin
					acc_q <= acc_q + mcand_q;
				end
				mcand_q <= mcand_q << 1;
				mr_q <= mr_q >> 1;
			end
			default: begin
			end
		endcase
	end

endmodule
`default_nettype wire
